### hdl/scpr_pkg.sv
package scpr_pkg;

    // sideband that travels with each beat
    typedef struct packed {
        logic ok;
        logic last;
    } t_side;

    // register indexes of the configuration port
    localparam logic [2:0] REG_START_ANGLE = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [2:0] REG_QUAT_W      = 3'd2;
    localparam logic [2:0] REG_QUAT_X      = 3'd3;
    localparam logic [2:0] REG_QUAT_Y      = 3'd4;
    localparam logic [2:0] REG_QUAT_Z      = 3'd5;
    localparam logic [2:0] REG_ORIENT_RDY  = 3'd6;

    // widths of the angle path and the cordic vector
    localparam int ANG_W = 34;
    localparam int XY_W  = 42;
    localparam int CX_W  = 26;
    localparam int MAX_CORDIC = 24;

    // angle constants, q16 radians
    localparam logic [19:0]        MOD_D     = 20'd411775;
    localparam logic [19:0]        Q_PI      = 20'd205887;
    localparam logic signed [20:0] Q_PI_S    = 21'sd205887;
    localparam logic signed [20:0] Q_HALF_S  = 21'sd102944;
    // multiple of two pi that makes every angle sum positive
    localparam logic signed [31:0] ANG_OFS   = 32'sd268889075;
    // floor(2^40 / two pi in q16)
    localparam logic [21:0]        RECIP     = 22'd2670175;
    // cordic gain in q30
    localparam logic signed [30:0] GAIN_Q30  = 31'sd652032874;

    localparam logic signed [ANG_W-1:0] ATAN_Q30 [MAX_CORDIC] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

endpackage

### hdl/scpr_angle.sv
module scpr_angle
    import scpr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  t_side                   i_side,
    input  logic [11:0]             i_idx,
    input  logic [23:0]             i_range,
    input  logic signed [18:0]      i_start_angle,
    input  logic signed [16:0]      i_angle_step,
    output logic                    o_vld,
    output t_side                   o_side,
    output logic [23:0]             o_range,
    output logic signed [ANG_W-1:0] o_z,
    output logic                    o_neg
);

    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_side              r_a_side, r_b_side, r_c_side, r_d_side;
    logic [23:0]        r_a_rng, r_b_rng, r_c_rng, r_d_rng;
    logic [29:0]        r_a_sum, r_b_sum;
    logic [10:0]        r_b_q;
    logic [20:0]        r_c_rem;
    logic signed [ANG_W-1:0] r_d_z;
    logic               r_d_neg;

    logic signed [29:0] w_prod;
    logic signed [31:0] w_sum;
    logic [51:0]        w_qp;
    logic [30:0]        w_qd;
    logic [29:0]        w_rem_full;
    logic [19:0]        w_r2;
    logic signed [20:0] w_a;
    logic signed [20:0] w_f;
    logic               w_neg;

    // angle sum shifted positive by a multiple of two pi
    assign w_prod = $signed({1'b0, i_idx}) * i_angle_step;
    assign w_sum  = 32'(i_start_angle) + 32'(w_prod) + ANG_OFS;

    // quotient estimate by reciprocal, low by at most one
    assign w_qp = 52'(r_a_sum) * 52'(RECIP);

    // remainder, below twice the modulus
    assign w_qd       = 31'(r_b_q) * 31'(MOD_D);
    assign w_rem_full = r_b_sum - w_qd[29:0];

    // final correction, map to (-pi, pi], fold into the right half plane
    assign w_r2 = (r_c_rem >= 21'(MOD_D)) ? 20'(r_c_rem - 21'(MOD_D)) : r_c_rem[19:0];
    assign w_a  = (w_r2 > Q_PI) ? ($signed({1'b0, w_r2}) - $signed({1'b0, MOD_D}))
                                : $signed({1'b0, w_r2});

    always_comb begin
        w_f   = w_a;
        w_neg = 1'b0;
        if (w_a > Q_HALF_S) begin
            w_f   = w_a - Q_PI_S;
            w_neg = 1'b1;
        end else if (w_a < -Q_HALF_S) begin
            w_f   = w_a + Q_PI_S;
            w_neg = 1'b1;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_a_side <= i_side;
        r_a_rng  <= i_range;
        r_a_sum  <= w_sum[29:0];
        r_b_side <= r_a_side;
        r_b_rng  <= r_a_rng;
        r_b_sum  <= r_a_sum;
        r_b_q    <= w_qp[50:40];
        r_c_side <= r_b_side;
        r_c_rng  <= r_b_rng;
        r_c_rem  <= w_rem_full[20:0];
        r_d_side <= r_c_side;
        r_d_rng  <= r_c_rng;
        r_d_z    <= ANG_W'(w_f) <<< 14;
        r_d_neg  <= w_neg;
    end

    assign o_vld   = r_d_vld;
    assign o_side  = r_d_side;
    assign o_range = r_d_rng;
    assign o_z     = r_d_z;
    assign o_neg   = r_d_neg;

`ifndef ASSERT_OFF
    // folded angle of a real sample lies within plus or minus pi/2
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld && r_d_side.ok) |->
            (r_d_z <= (ANG_W'(Q_HALF_S) <<< 14) && r_d_z >= -(ANG_W'(Q_HALF_S) <<< 14)))
        else $error("folded angle out of range");
`endif

endmodule

### hdl/scpr_cordic.sv
module scpr_cordic
    import scpr_pkg::*;
#(
    parameter int NS = 16
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  t_side                   i_side,
    input  logic [23:0]             i_range,
    input  logic signed [ANG_W-1:0] i_z,
    input  logic                    i_neg,
    output logic                    o_vld,
    output t_side                   o_side,
    output logic                    o_neg,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [XY_W-1:0]  o_y
);

    logic                    r_v [NS+1];
    t_side                   r_s [NS+1];
    logic                    r_n [NS+1];
    logic signed [XY_W-1:0]  r_x [NS+1];
    logic signed [XY_W-1:0]  r_y [NS+1];
    logic signed [ANG_W-1:0] r_z [NS+1];

    // valid bits through all rotation stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_vld;
            for (int i = 0; i < NS; i++) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    // load stage and one micro-rotation per stage
    always_ff @(posedge i_clk) begin
        r_s[0] <= i_side;
        r_n[0] <= i_neg;
        r_x[0] <= XY_W'($signed({1'b0, i_range, 14'b0}));
        r_y[0] <= '0;
        r_z[0] <= i_z;
        for (int i = 0; i < NS; i++) begin
            r_s[i+1] <= r_s[i];
            r_n[i+1] <= r_n[i];
            if (!r_z[i][ANG_W-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ATAN_Q30[i];
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ATAN_Q30[i];
            end
        end
    end

    assign o_vld  = r_v[NS];
    assign o_side = r_s[NS];
    assign o_neg  = r_n[NS];
    assign o_x    = r_x[NS];
    assign o_y    = r_y[NS];

`ifndef ASSERT_OFF
    // a beat leaving the last stage entered the first one
    a_cordic_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] |-> $past(r_v[0], NS))
        else $error("cordic valid chain broken");
`endif

endmodule

### hdl/scpr_rotate.sv
module scpr_rotate
    import scpr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  t_side                  i_side,
    input  logic                   i_neg,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [15:0]     i_qw,
    input  logic signed [15:0]     i_qx,
    input  logic signed [15:0]     i_qy,
    input  logic signed [15:0]     i_qz,
    output logic                   o_strobe,
    output logic                   o_point_valid,
    output logic signed [24:0]     o_point_x,
    output logic signed [24:0]     o_point_y,
    output logic signed [24:0]     o_point_z,
    output logic                   o_last_of_scan
);

    // rotation matrix from the quaternion, two register stages
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [33:0] r_m11, r_m12, r_m21, r_m22, r_m31, r_m32;

    always_ff @(posedge i_clk) begin
        r_ww  <= i_qw * i_qw;
        r_xx  <= i_qx * i_qx;
        r_yy  <= i_qy * i_qy;
        r_zz  <= i_qz * i_qz;
        r_xy  <= i_qx * i_qy;
        r_wz  <= i_qw * i_qz;
        r_xz  <= i_qx * i_qz;
        r_wy  <= i_qw * i_qy;
        r_yz  <= i_qy * i_qz;
        r_wx  <= i_qw * i_qx;
        r_m11 <= 34'(r_ww) + 34'(r_xx) - 34'(r_yy) - 34'(r_zz);
        r_m22 <= 34'(r_ww) - 34'(r_xx) + 34'(r_yy) - 34'(r_zz);
        r_m12 <= (34'(r_xy) - 34'(r_wz)) <<< 1;
        r_m21 <= (34'(r_xy) + 34'(r_wz)) <<< 1;
        r_m31 <= (34'(r_xz) - 34'(r_wy)) <<< 1;
        r_m32 <= (34'(r_yz) + 34'(r_wx)) <<< 1;
    end

    logic               r_g1_vld, r_g2_vld, r_p_vld;
    t_side              r_g1_side, r_g2_side, r_p_side;
    logic               r_g1_neg;
    logic signed [58:0] r_g1_px, r_g1_py;
    logic signed [CX_W-1:0] r_g2_cx, r_g2_cy;
    logic signed [59:0] r_p11, r_p12, r_p21, r_p22, r_p31, r_p32;

    logic signed [XY_W-1:0] w_xr_full, w_yr_full;
    logic signed [27:0]     w_xr, w_yr;
    logic signed [58:0]     w_cxr_full, w_cyr_full;
    logic signed [CX_W-1:0] w_cx, w_cy;

    // round to q16 and apply the gain
    assign w_xr_full = (i_x + XY_W'(8192)) >>> 14;
    assign w_yr_full = (i_y + XY_W'(8192)) >>> 14;
    assign w_xr      = w_xr_full[27:0];
    assign w_yr      = w_yr_full[27:0];

    // round the gain product, undo the fold
    assign w_cxr_full = (r_g1_px + (59'sd1 <<< 29)) >>> 30;
    assign w_cyr_full = (r_g1_py + (59'sd1 <<< 29)) >>> 30;
    assign w_cx = r_g1_neg ? -w_cxr_full[CX_W-1:0] : w_cxr_full[CX_W-1:0];
    assign w_cy = r_g1_neg ? -w_cyr_full[CX_W-1:0] : w_cyr_full[CX_W-1:0];

    // row sums, rounding from q28 and saturation
    function automatic logic signed [24:0] f_row(input logic signed [59:0] a,
                                                 input logic signed [59:0] b);
        logic signed [60:0] s;
        logic signed [32:0] h;
        s = 61'(a) + 61'(b) + (61'sd1 <<< 27);
        h = 33'(s >>> 28);
        if (h > 33'sd16777215) begin
            f_row = 25'sd16777215;
        end else if (h < -33'sd16777216) begin
            f_row = -25'sd16777216;
        end else begin
            f_row = h[24:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_vld <= 1'b0;
            r_g2_vld <= 1'b0;
            r_p_vld  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_g1_vld <= i_vld;
            r_g2_vld <= r_g1_vld;
            r_p_vld  <= r_g2_vld;
            o_strobe <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1_side <= i_side;
        r_g1_neg  <= i_neg;
        r_g1_px   <= w_xr * GAIN_Q30;
        r_g1_py   <= w_yr * GAIN_Q30;
        r_g2_side <= r_g1_side;
        r_g2_cx   <= w_cx;
        r_g2_cy   <= w_cy;
        r_p_side  <= r_g2_side;
        r_p11     <= r_m11 * r_g2_cx;
        r_p12     <= r_m12 * r_g2_cy;
        r_p21     <= r_m21 * r_g2_cx;
        r_p22     <= r_m22 * r_g2_cy;
        r_p31     <= r_m31 * r_g2_cx;
        r_p32     <= r_m32 * r_g2_cy;
        o_point_valid  <= r_p_side.ok;
        o_last_of_scan <= r_p_side.last;
        o_point_x <= r_p_side.ok ? f_row(r_p11, r_p12) : '0;
        o_point_y <= r_p_side.ok ? f_row(r_p21, r_p22) : '0;
        o_point_z <= r_p_side.ok ? f_row(r_p31, r_p32) : '0;
    end

`ifndef ASSERT_OFF
    // a skipped sample carries a zero point
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_point_valid) |->
            (o_point_x == 25'sd0 && o_point_y == 25'sd0 && o_point_z == 25'sd0))
        else $error("skipped sample with nonzero point");
`endif

endmodule

### hdl/scan_polar_to_rotated_point.sv
// Turns one laser range sample per beat into a rotated 3-D point. A beat is
// taken on every clock with start high and busy low; busy is high only in
// reset. Each beat gives exactly one result, shown for a single cycle with
// o_strobe (at most 24 of the CORDIC_STAGES count); the receiver cannot
// stall it. A fully pipelined path sustains one beat per cycle: four
// stages of angle reduction, one load stage plus one stage per cordic
// micro-rotation, then gain, fold undo, matrix products and the rounded,
// saturated row sums. After a quaternion write the rotation matrix is
// rebuilt, the products registered first and then the matrix terms.
// Invalid ranges, indexes at or above MAX_SAMPLES and all samples before
// orientation_ready give a zero point with o_point_valid low.
module scan_polar_to_rotated_point
    import scpr_pkg::*;
#(
    parameter int MAX_SAMPLES   = 4096,
    parameter int CORDIC_STAGES = 16
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [11:0]        i_sample_index,
    input  logic [23:0]        i_range_value,
    input  logic               i_range_invalid,
    input  logic               i_scan_end,
    input  logic               i_cfg_wr,
    input  logic [2:0]         i_cfg_addr,
    input  logic [18:0]        i_cfg_data,
    output logic               o_strobe,
    output logic               o_point_valid,
    output logic signed [24:0] o_point_x,
    output logic signed [24:0] o_point_y,
    output logic signed [24:0] o_point_z,
    output logic               o_last_of_scan
);

    localparam int NS  = (CORDIC_STAGES > MAX_CORDIC) ? MAX_CORDIC : CORDIC_STAGES;
    localparam int LAT = NS + 9;

    logic signed [18:0] r_start_angle;
    logic signed [16:0] r_angle_step;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic               r_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_angle_step  <= '0;
            r_qw          <= 16'sd16384;
            r_qx          <= '0;
            r_qy          <= '0;
            r_qz          <= '0;
            r_ready       <= 1'b0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_addr)
                REG_START_ANGLE: r_start_angle <= i_cfg_data;
                REG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[16:0];
                REG_QUAT_W:      r_qw          <= i_cfg_data[15:0];
                REG_QUAT_X:      r_qx          <= i_cfg_data[15:0];
                REG_QUAT_Y:      r_qy          <= i_cfg_data[15:0];
                REG_QUAT_Z:      r_qz          <= i_cfg_data[15:0];
                REG_ORIENT_RDY:  r_ready       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic  w_acc;
    t_side w_side;

    // beat acceptance and skip decision
    assign busy        = ~i_rst_n;
    assign w_acc       = start & ~busy;
    assign w_side.ok   = ~i_range_invalid & r_ready &
                         (17'(i_sample_index) < 17'(MAX_SAMPLES));
    assign w_side.last = i_scan_end;

    logic                    a_vld, c_vld;
    t_side                   a_side, c_side;
    logic [23:0]             a_range;
    logic signed [ANG_W-1:0] a_z;
    logic                    a_neg, c_neg;
    logic signed [XY_W-1:0]  c_x, c_y;

    scpr_angle u_angle (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (w_acc),
        .i_side        (w_side),
        .i_idx         (i_sample_index),
        .i_range       (i_range_value),
        .i_start_angle (r_start_angle),
        .i_angle_step  (r_angle_step),
        .o_vld         (a_vld),
        .o_side        (a_side),
        .o_range       (a_range),
        .o_z           (a_z),
        .o_neg         (a_neg)
    );

    scpr_cordic #(.NS(NS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (a_vld),
        .i_side  (a_side),
        .i_range (a_range),
        .i_z     (a_z),
        .i_neg   (a_neg),
        .o_vld   (c_vld),
        .o_side  (c_side),
        .o_neg   (c_neg),
        .o_x     (c_x),
        .o_y     (c_y)
    );

    scpr_rotate u_rotate (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (c_vld),
        .i_side         (c_side),
        .i_neg          (c_neg),
        .i_x            (c_x),
        .i_y            (c_y),
        .i_qw           (r_qw),
        .i_qx           (r_qx),
        .i_qy           (r_qy),
        .i_qz           (r_qz),
        .o_strobe       (o_strobe),
        .o_point_valid  (o_point_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_z      (o_point_z),
        .o_last_of_scan (o_last_of_scan)
    );

`ifndef ASSERT_OFF
    // every result comes from a matching accepted beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, LAT))
        else $error("result without matching input beat");
`endif

endmodule
